[src/fvu_pkg.sv]
// fvu_pkg: operation codes, default widths and saturation helpers for the
// fixed-point vector unit; no dependencies
`default_nettype none

package fvu_pkg;

	localparam int DEF_FRACTION_BITS = 16;
	localparam int ROOT_W            = 32;

	typedef enum logic [2:0] {
		OP_ISQRT64   = 3'd0,
		OP_SQRT      = 3'd1,
		OP_DOT       = 3'd2,
		OP_CROSS     = 3'd3,
		OP_LENGTH    = 3'd4,
		OP_LENGTH_SQ = 3'd5,
		OP_NORMALIZE = 3'd6,
		OP_CLAMP     = 3'd7
	} op_t;

	localparam logic [31:0] S32_MAX = 32'h7fff_ffff;
	localparam logic [31:0] S32_MIN = 32'h8000_0000;

	// 65-bit signed sum down to saturated 64 bits
	function automatic logic [63:0] sat64(input logic [64:0] s);
		logic [63:0] r;
		if (s[64] != s[63]) begin
			r = s[64] ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
		end else begin
			r = s[63:0];
		end
		return r;
	endfunction

	// signed 64 bits to saturated signed 32 bits
	function automatic logic [31:0] sat32(input logic [63:0] v);
		logic [31:0] r;
		if ((v[63:31] == '0) || (v[63:31] == '1)) begin
			r = v[31:0];
		end else begin
			r = v[63] ? S32_MIN : S32_MAX;
		end
		return r;
	endfunction

	// non-negative 32-bit value to the signed range
	function automatic logic [31:0] sat_u32(input logic [31:0] u);
		return u[31] ? S32_MAX : u;
	endfunction

	// signed quotient from sign and magnitude, saturated
	function automatic logic [31:0] sat_quot(input logic neg, input logic [31:0] q);
		logic [31:0] r;
		if (!neg) begin
			r = q[31] ? S32_MAX : q;
		end else if (q > S32_MIN) begin
			r = S32_MIN;
		end else begin
			r = -q;
		end
		return r;
	endfunction

	function automatic logic [31:0] abs32(input logic [31:0] v);
		return v[31] ? -v : v;
	endfunction

	function automatic logic [63:0] abs64(input logic [63:0] v);
		return v[63] ? -v : v;
	endfunction

endpackage

`default_nettype wire

[src/fixed_point_vec2_unit.sv]
// fixed_point_vec2_unit: pipelined Q16.16 2-d vector unit with integer root
// and saturating divide; depends on fvu_pkg
//
// one transaction in, one out, every cycle unless stalled. each item names an
// operation (64-bit integer root, Q-format root, dot, cross, length, squared
// length, normalize, clamp to a length limit) and the pipeline runs every item
// through the same 69 register stages: three for the products and sums, 32
// for the root (one root bit per stage), one divide setup stage, 32 for the
// two parallel dividers (one quotient bit per stage) and the output register.
// the accepting edge loads the first stage, and the sustained rate is one item per
// clock while in_ready stays high. a one-entry skid buffer behind the output
// register keeps the input open while a finished result waits; only when both
// are full does in_ready drop, and then the whole pipeline holds.
// quotients are truncated toward zero, every Q-format result saturates to the
// signed 32-bit range, and zero or negative lengths and limits give zero.
`default_nettype none

module fixed_point_vec2_unit #(
	parameter int FRACTION_BITS = fvu_pkg::DEF_FRACTION_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         op,
	input  logic signed [31:0] a_x,
	input  logic signed [31:0] a_y,
	input  logic signed [31:0] b_x,
	input  logic signed [31:0] b_y,
	input  logic signed [31:0] length_limit,
	input  logic signed [31:0] scalar_operand,
	input  logic signed [63:0] wide_operand,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] result_x,
	output logic signed [31:0] result_y,
	output logic signed [32:0] result_scalar
);
	import fvu_pkg::*;

	localparam int FB        = FRACTION_BITS;
	localparam int EB        = FRACTION_BITS / 2;        // extra bits for precise normalize
	localparam int PREC_BITS = 62 - 2 * EB;
	localparam int NUM_W     = (32 + FB + EB > 63) ? (32 + FB + EB) : 63;
	localparam int HI_W      = NUM_W - 32;
	localparam int SQ_N      = ROOT_W;                   // root stages
	localparam int DV_N      = 32;                       // quotient stages

	typedef struct packed {
		op_t               op;
		logic [31:0]       ax;
		logic [31:0]       ay;
		logic              neg_x;
		logic              neg_y;
		logic [NUM_W-1:0]  num_x;
		logic [NUM_W-1:0]  num_y;
		logic              precise;
		logic              pass;
		logic              lim_pos;
		logic              len_zero;
		logic [31:0]       direct;
		logic              ovf_x;
		logic              ovf_y;
	} carry_t;

	// whole pipeline advances unless the skid buffer is occupied
	logic skid_v_q;
	logic en;
	assign en       = !skid_v_q;
	assign in_ready = en;

	// ---------------------------------------------------------------- stage 1
	// all raw products, one 32x32 multiplier each
	logic        v_s1;
	op_t         op_s1;
	logic [31:0] ax_s1, ay_s1, lim_s1, sc_s1;
	logic [63:0] wide_s1;
	logic signed [63:0] pxx_s1, pyy_s1, pxbx_s1, pyby_s1, pxby_s1, pybx_s1;
	logic signed [63:0] pxl_s1, pyl_s1, pll_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1   <= op_t'(op);
			ax_s1   <= a_x;
			ay_s1   <= a_y;
			lim_s1  <= length_limit;
			sc_s1   <= scalar_operand;
			wide_s1 <= wide_operand;
			pxx_s1  <= a_x * a_x;
			pyy_s1  <= a_y * a_y;
			pxbx_s1 <= a_x * b_x;
			pyby_s1 <= a_y * b_y;
			pxby_s1 <= a_x * b_y;
			pybx_s1 <= a_y * b_x;
			pxl_s1  <= a_x * length_limit;
			pyl_s1  <= a_y * length_limit;
			pll_s1  <= length_limit * length_limit;
		end
	end

	// ---------------------------------------------------------------- stage 2
	// saturating sums of two products
	logic        v_s2;
	op_t         op_s2;
	logic [31:0] ax_s2, ay_s2, lim_s2, sc_s2;
	logic [63:0] wide_s2, len2_s2, dot_s2, cross_s2, pxl_s2, pyl_s2, pll_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s2    <= op_s1;
			ax_s2    <= ax_s1;
			ay_s2    <= ay_s1;
			lim_s2   <= lim_s1;
			sc_s2    <= sc_s1;
			wide_s2  <= wide_s1;
			len2_s2  <= sat64({pxx_s1[63], pxx_s1} + {pyy_s1[63], pyy_s1});
			dot_s2   <= sat64({pxbx_s1[63], pxbx_s1} + {pyby_s1[63], pyby_s1});
			cross_s2 <= sat64({pxby_s1[63], pxby_s1} - {pybx_s1[63], pybx_s1});
			pxl_s2   <= pxl_s1;
			pyl_s2   <= pyl_s1;
			pll_s2   <= pll_s1;
		end
	end

	// ---------------------------------------------------------------- stage 3
	// root operand, direct scalar results, divide numerators
	logic        precise_c;
	logic [63:0] rad_c;
	logic [31:0] direct_c;
	logic [NUM_W-1:0] norm_x_c, norm_y_c, num_x_c, num_y_c;
	carry_t      c3_c;

	always_comb begin
		precise_c = (len2_s2[63:PREC_BITS] == '0);
		rad_c     = '0;
		direct_c  = '0;
		norm_x_c  = precise_c ? (NUM_W'(abs32(ax_s2)) << (FB + EB))
		                      : (NUM_W'(abs32(ax_s2)) << FB);
		norm_y_c  = precise_c ? (NUM_W'(abs32(ay_s2)) << (FB + EB))
		                      : (NUM_W'(abs32(ay_s2)) << FB);
		num_x_c   = NUM_W'(abs64(pxl_s2));
		num_y_c   = NUM_W'(abs64(pyl_s2));
		case (op_s2)
			OP_ISQRT64: begin
				if (!wide_s2[63]) begin
					rad_c = wide_s2;
				end
			end
			OP_SQRT: begin
				if (!sc_s2[31] && (sc_s2 != '0)) begin
					rad_c = {{32{1'b0}}, sc_s2} << FB;
				end
			end
			OP_DOT:       direct_c = sat32($signed(dot_s2) >>> FB);
			OP_CROSS:     direct_c = sat32($signed(cross_s2) >>> FB);
			OP_LENGTH_SQ: direct_c = sat32($signed(len2_s2) >>> FB);
			OP_LENGTH:    rad_c = len2_s2;
			OP_NORMALIZE: begin
				rad_c   = precise_c ? (len2_s2 << (2 * EB)) : len2_s2;
				num_x_c = norm_x_c;
				num_y_c = norm_y_c;
			end
			OP_CLAMP:     rad_c = len2_s2;
			default: ;
		endcase
		c3_c.op       = op_s2;
		c3_c.ax       = ax_s2;
		c3_c.ay       = ay_s2;
		c3_c.neg_x    = ax_s2[31];
		c3_c.neg_y    = ay_s2[31];
		c3_c.num_x    = num_x_c;
		c3_c.num_y    = num_y_c;
		c3_c.precise  = precise_c;
		c3_c.pass     = ($signed(len2_s2) <= $signed(pll_s2));
		c3_c.lim_pos  = !lim_s2[31] && (lim_s2 != '0);
		c3_c.len_zero = (len2_s2 == '0);
		c3_c.direct   = direct_c;
		c3_c.ovf_x    = 1'b0;
		c3_c.ovf_y    = 1'b0;
	end

	logic        v_s3;
	logic [63:0] rad_s3;
	carry_t      c_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s3 <= rad_c;
			c_s3   <= c3_c;
		end
	end

	// ---------------------------------------------------------- root pipeline
	// restoring square root, two radicand bits and one root bit per stage
	logic        sq_v_s    [1:SQ_N];
	logic [33:0] sq_rem_s  [1:SQ_N];
	logic [31:0] sq_root_s [1:SQ_N];
	logic [63:0] sq_opnd_s [1:SQ_N];
	carry_t      sq_c_s    [1:SQ_N];

	for (genvar k = 0; k < SQ_N; k++) begin : g_sq
		logic        v_i;
		logic [33:0] rem_i, r_i, t_i;
		logic [31:0] root_i;
		logic [63:0] opnd_i;
		carry_t      c_i;
		logic        ge_i;

		if (k == 0) begin : g_first
			assign v_i    = v_s3;
			assign rem_i  = '0;
			assign root_i = '0;
			assign opnd_i = rad_s3;
			assign c_i    = c_s3;
		end else begin : g_next
			assign v_i    = sq_v_s[k];
			assign rem_i  = sq_rem_s[k];
			assign root_i = sq_root_s[k];
			assign opnd_i = sq_opnd_s[k];
			assign c_i    = sq_c_s[k];
		end

		assign r_i  = {rem_i[31:0], opnd_i[63:62]};
		assign t_i  = {root_i, 2'b01};
		assign ge_i = (r_i >= t_i);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_s[k+1] <= 1'b0;
			end else if (en) begin
				sq_v_s[k+1] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_rem_s[k+1]  <= ge_i ? (r_i - t_i) : r_i;
				sq_root_s[k+1] <= {root_i[30:0], ge_i};
				sq_opnd_s[k+1] <= {opnd_i[61:0], 2'b00};
				sq_c_s[k+1]    <= c_i;
			end
		end
	end

	// ------------------------------------------------------------ divide setup
	// quotient of 2^32 or more saturates anyway; otherwise the high part
	// seeds the remainder and 32 quotient bits remain
	logic [HI_W-1:0] hi_x_c, hi_y_c;
	carry_t          cds_c;

	always_comb begin
		hi_x_c      = sq_c_s[SQ_N].num_x[NUM_W-1:32];
		hi_y_c      = sq_c_s[SQ_N].num_y[NUM_W-1:32];
		cds_c       = sq_c_s[SQ_N];
		// root may use all 32 bits, so compare one bit wider than the high part
		cds_c.ovf_x = ((HI_W+1)'(hi_x_c) >= (HI_W+1)'(sq_root_s[SQ_N]));
		cds_c.ovf_y = ((HI_W+1)'(hi_y_c) >= (HI_W+1)'(sq_root_s[SQ_N]));
	end

	logic        ds_v_s;
	logic [31:0] ds_root_s, ds_rx_s, ds_ry_s, ds_lx_s, ds_ly_s;
	carry_t      ds_c_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ds_v_s <= 1'b0;
		end else if (en) begin
			ds_v_s <= sq_v_s[SQ_N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ds_root_s <= sq_root_s[SQ_N];
			ds_rx_s   <= 32'(hi_x_c);
			ds_ry_s   <= 32'(hi_y_c);
			ds_lx_s   <= sq_c_s[SQ_N].num_x[31:0];
			ds_ly_s   <= sq_c_s[SQ_N].num_y[31:0];
			ds_c_s    <= cds_c;
		end
	end

	// -------------------------------------------------------- divide pipeline
	// two restoring dividers sharing the root as divisor
	logic        dv_v_s    [1:DV_N];
	logic [31:0] dv_root_s [1:DV_N];
	logic [31:0] dv_rx_s   [1:DV_N];
	logic [31:0] dv_ry_s   [1:DV_N];
	logic [31:0] dv_lx_s   [1:DV_N];
	logic [31:0] dv_ly_s   [1:DV_N];
	logic [31:0] dv_qx_s   [1:DV_N];
	logic [31:0] dv_qy_s   [1:DV_N];
	carry_t      dv_c_s    [1:DV_N];

	for (genvar k = 0; k < DV_N; k++) begin : g_dv
		logic        v_i;
		logic [31:0] root_i, rx_i, ry_i, lx_i, ly_i, qx_i, qy_i;
		logic [32:0] px_i, py_i;
		logic        gx_i, gy_i;
		carry_t      c_i;

		if (k == 0) begin : g_first
			assign v_i    = ds_v_s;
			assign root_i = ds_root_s;
			assign rx_i   = ds_rx_s;
			assign ry_i   = ds_ry_s;
			assign lx_i   = ds_lx_s;
			assign ly_i   = ds_ly_s;
			assign qx_i   = '0;
			assign qy_i   = '0;
			assign c_i    = ds_c_s;
		end else begin : g_next
			assign v_i    = dv_v_s[k];
			assign root_i = dv_root_s[k];
			assign rx_i   = dv_rx_s[k];
			assign ry_i   = dv_ry_s[k];
			assign lx_i   = dv_lx_s[k];
			assign ly_i   = dv_ly_s[k];
			assign qx_i   = dv_qx_s[k];
			assign qy_i   = dv_qy_s[k];
			assign c_i    = dv_c_s[k];
		end

		assign px_i = {rx_i, lx_i[31]};
		assign py_i = {ry_i, ly_i[31]};
		assign gx_i = (px_i >= {1'b0, root_i});
		assign gy_i = (py_i >= {1'b0, root_i});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[k+1] <= 1'b0;
			end else if (en) begin
				dv_v_s[k+1] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_root_s[k+1] <= root_i;
				dv_rx_s[k+1]   <= gx_i ? 32'(px_i - {1'b0, root_i}) : px_i[31:0];
				dv_ry_s[k+1]   <= gy_i ? 32'(py_i - {1'b0, root_i}) : py_i[31:0];
				dv_lx_s[k+1]   <= {lx_i[30:0], 1'b0};
				dv_ly_s[k+1]   <= {ly_i[30:0], 1'b0};
				dv_qx_s[k+1]   <= {qx_i[30:0], gx_i};
				dv_qy_s[k+1]   <= {qy_i[30:0], gy_i};
				dv_c_s[k+1]    <= c_i;
			end
		end
	end

	// ------------------------------------------------------ result selection
	carry_t      cf_c;
	logic [31:0] root_f, qx_f, qy_f, lenr_f;
	logic [31:0] fx_c, fy_c;
	logic [32:0] fs_c;

	always_comb begin
		cf_c   = dv_c_s[DV_N];
		root_f = dv_root_s[DV_N];
		qx_f   = cf_c.ovf_x ? '1 : dv_qx_s[DV_N];
		qy_f   = cf_c.ovf_y ? '1 : dv_qy_s[DV_N];
		lenr_f = sat_u32(cf_c.precise ? (root_f >> EB) : root_f);
		fx_c   = '0;
		fy_c   = '0;
		fs_c   = '0;
		case (cf_c.op)
			OP_ISQRT64: fs_c = {1'b0, root_f};
			OP_SQRT, OP_LENGTH: fs_c = {1'b0, sat_u32(root_f)};
			OP_DOT, OP_CROSS, OP_LENGTH_SQ: fs_c = {cf_c.direct[31], cf_c.direct};
			OP_NORMALIZE: begin
				if (!cf_c.len_zero) begin
					fx_c = sat_quot(cf_c.neg_x, qx_f);
					fy_c = sat_quot(cf_c.neg_y, qy_f);
					fs_c = {1'b0, lenr_f};
				end
			end
			OP_CLAMP: begin
				if (cf_c.lim_pos) begin
					if (cf_c.pass || (root_f == '0)) begin
						fx_c = cf_c.ax;
						fy_c = cf_c.ay;
					end else begin
						fx_c = sat_quot(cf_c.neg_x, qx_f);
						fy_c = sat_quot(cf_c.neg_y, qy_f);
					end
				end
			end
			default: ;
		endcase
	end

	// ------------------------------------------------ output register and skid
	logic        out_v_q;
	logic [31:0] out_x_q, out_y_q, sk_x_q, sk_y_q;
	logic [32:0] out_s_q, sk_s_q;
	logic        take;

	assign take = out_v_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (skid_v_q) begin
				if (take) begin
					skid_v_q <= 1'b0;
				end
			end else if (dv_v_s[DV_N]) begin
				if (!out_v_q || take) begin
					out_v_q <= 1'b1;
				end else begin
					skid_v_q <= 1'b1;
				end
			end else if (take) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (take) begin
				out_x_q <= sk_x_q;
				out_y_q <= sk_y_q;
				out_s_q <= sk_s_q;
			end
		end else if (dv_v_s[DV_N]) begin
			if (!out_v_q || take) begin
				out_x_q <= fx_c;
				out_y_q <= fy_c;
				out_s_q <= fs_c;
			end else begin
				sk_x_q <= fx_c;
				sk_y_q <= fy_c;
				sk_s_q <= fs_c;
			end
		end
	end

	assign out_valid     = out_v_q;
	assign result_x      = out_x_q;
	assign result_y      = out_y_q;
	assign result_scalar = out_s_q;

	// ------------------------------------------------------------- assertions
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid buffer holds data while output register is empty");

	a_stall_to_skid: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !out_ready && dv_v_s[DV_N] && !skid_v_q) |=> skid_v_q)
		else $error("finished result dropped while output stalled");

	a_root_range: assert property (@(posedge clk) disable iff (!arst_n)
		sq_v_s[SQ_N] |-> (sq_root_s[SQ_N] <= 32'd3037000499))
		else $error("root exceeds floor root of the largest radicand");

	a_zero_len_root: assert property (@(posedge clk) disable iff (!arst_n)
		(sq_v_s[SQ_N] && (sq_c_s[SQ_N].op == OP_NORMALIZE) && sq_c_s[SQ_N].len_zero)
		|-> (sq_root_s[SQ_N] == '0))
		else $error("zero-length normalize produced a non-zero root");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(dv_v_s[DV_N] && !dv_c_s[DV_N].ovf_x) |-> (dv_rx_s[DV_N] < dv_root_s[DV_N]))
		else $error("divider remainder not below divisor");

endmodule

`default_nettype wire
